// ===== hw/rtl/char_lcd_parallel_sequencer_core_defines.svh =====
// Assertion macros shared by the sequencer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CHAR_LCD_PARALLEL_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_PARALLEL_SEQUENCER_CORE_DEFINES_SVH
`ifndef SYNTH
`define CLPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CLPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CLPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLPS_ASSERT(lbl, prop, msg)
`define CLPS_ASSERT_IMP(lbl, ante, cons, msg)
`define CLPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/clps_pkg.sv =====
`default_nettype none
package clps_pkg;

  // Default width of the microsecond wait counter.
  localparam int unsigned WAIT_BITS_DEF = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] POWER_UP_WAIT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] SETTLE_WAIT_RST = 16'd90;
  localparam logic [CFG_W-1:0] LONG_WAIT_RST = 16'd4000;

  // Fixed gaps of the power-up sequence, in microseconds.
  localparam int unsigned GAP_A_US = 7 * 1000;
  localparam int unsigned GAP_B_US = 2 * 1000;

  // Instruction bytes and opcode bases.
  localparam logic [7:0] BYTE_WAKE = 8'h30;
  localparam logic [7:0] BYTE_FUNC_INIT = 8'h38;
  localparam logic [7:0] BYTE_DISP_OFF = 8'h08;
  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] BYTE_HOME = 8'h02;
  localparam logic [7:0] BYTE_ENTRY_INIT = 8'h06;
  localparam logic [7:0] BASE_ENTRY = 8'h04;
  localparam logic [7:0] BASE_DISPLAY = 8'h08;
  localparam logic [7:0] BASE_SHIFT = 8'h10;
  localparam logic [7:0] BASE_FUNC = 8'h20;
  localparam logic [7:0] BASE_CGRAM = 8'h40;
  localparam logic [7:0] BASE_DDRAM = 8'h80;

  // Positions in the power-up sequence.
  localparam logic [3:0] STEP_POWER_UP = 4'd0;
  localparam logic [3:0] STEP_WAKE_1 = 4'd1;
  localparam logic [3:0] STEP_GAP_A = 4'd2;
  localparam logic [3:0] STEP_WAKE_2 = 4'd3;
  localparam logic [3:0] STEP_GAP_B = 4'd4;
  localparam logic [3:0] STEP_WAKE_3 = 4'd5;
  localparam logic [3:0] STEP_FUNC = 4'd6;
  localparam logic [3:0] STEP_DISP_OFF = 4'd7;
  localparam logic [3:0] STEP_CLEAR = 4'd8;
  localparam logic [3:0] STEP_ENTRY = 4'd9;

  typedef enum logic [3:0] {
    CMD_INIT     = 4'd0,
    CMD_CLEAR    = 4'd1,
    CMD_HOME     = 4'd2,
    CMD_ENTRY    = 4'd3,
    CMD_DISPLAY  = 4'd4,
    CMD_SHIFT    = 4'd5,
    CMD_FUNCTION = 4'd6,
    CMD_CGRAM    = 4'd7,
    CMD_DDRAM    = 4'd8,
    CMD_DATA     = 4'd9
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_UP = 2'd0,
    CFG_SETTLE   = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PULSE  = 3'd1,
    PH_SETTLE = 3'd2,
    PH_LONG   = 3'd3,
    PH_GAP    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    INIT_NONE = 2'd0,
    INIT_RUN  = 2'd1,
    INIT_DONE = 2'd2
  } init_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_INIT  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  typedef struct packed {
    logic       mode;
    logic [3:0] command;
    logic       flag_a;
    logic       flag_b;
    logic       flag_c;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [7:0] bus_data;
    logic       busy_res;
    logic       rejected;
    logic       ready_res;
  } out_item_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] wr_byte;
    logic       wr_select;
    logic       wr_long;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/clps_front.sv =====
`default_nettype none
`include "char_lcd_parallel_sequencer_core_defines.svh"
module clps_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire clps_pkg::in_item_t  in_item_i,
  input  wire logic                q_full_i,
  output logic                     in_stall_o,
  output logic                     push_o,
  output clps_pkg::entry_t         entry_o
);

  // Stall while the queue has no free slot.
  assign in_stall_o = q_full_i;
  assign push_o = in_valid_i && !q_full_i;

  // Classify each item and turn a request into the byte, select and long-wait flag it will write.
  always_comb begin
    entry_o.kind = clps_pkg::KIND_TICK;
    entry_o.wr_byte = 8'h00;
    entry_o.wr_select = 1'b0;
    entry_o.wr_long = 1'b0;
    if (in_item_i.mode) begin
      entry_o.kind = clps_pkg::KIND_WRITE;
      unique case (clps_pkg::cmd_e'(in_item_i.command))
        clps_pkg::CMD_INIT: begin
          entry_o.kind = clps_pkg::KIND_INIT;
        end
        clps_pkg::CMD_CLEAR: begin
          entry_o.wr_byte = clps_pkg::BYTE_CLEAR;
          entry_o.wr_long = 1'b1;
        end
        clps_pkg::CMD_HOME: begin
          entry_o.wr_byte = clps_pkg::BYTE_HOME;
          entry_o.wr_long = 1'b1;
        end
        clps_pkg::CMD_ENTRY: begin
          entry_o.wr_byte = clps_pkg::BASE_ENTRY | {6'b0, in_item_i.flag_a, 1'b0};
        end
        clps_pkg::CMD_DISPLAY: begin
          entry_o.wr_byte = clps_pkg::BASE_DISPLAY |
              {5'b0, in_item_i.flag_a, in_item_i.flag_b, in_item_i.flag_c};
        end
        clps_pkg::CMD_SHIFT: begin
          entry_o.wr_byte = clps_pkg::BASE_SHIFT |
              {4'b0, in_item_i.flag_a, in_item_i.flag_b, 2'b0};
        end
        clps_pkg::CMD_FUNCTION: begin
          entry_o.wr_byte = clps_pkg::BASE_FUNC |
              {3'b0, in_item_i.flag_a, in_item_i.flag_b, in_item_i.flag_c, 2'b0};
        end
        clps_pkg::CMD_CGRAM: begin
          entry_o.wr_byte = clps_pkg::BASE_CGRAM | {2'b0, in_item_i.value[5:0]};
        end
        clps_pkg::CMD_DDRAM: begin
          entry_o.wr_byte = clps_pkg::BASE_DDRAM | {1'b0, in_item_i.value[6:0]};
        end
        clps_pkg::CMD_DATA: begin
          entry_o.wr_byte = in_item_i.value;
          entry_o.wr_select = 1'b1;
        end
        default: begin
          entry_o.kind = clps_pkg::KIND_BAD;
        end
      endcase
    end
  end

  // The front holds no state of its own; clock and reset are kept for the checks.
  `CLPS_ASSERT_IMP(a_front_no_push_full, q_full_i, !push_o,
                   "front pushed into a full queue")

endmodule
`default_nettype wire

// ===== hw/rtl/clps_queue.sv =====
`default_nettype none
`include "char_lcd_parallel_sequencer_core_defines.svh"
module clps_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire clps_pkg::entry_t  entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output clps_pkg::entry_t       entry_o
);

  localparam int unsigned DEPTH = clps_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  clps_pkg::entry_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `CLPS_ASSERT(a_queue_count_range, count_q <= FULL_CNT, "queue count above depth")
  `CLPS_ASSERT_IMP(a_queue_pop_nonempty, pop_i, count_q != '0, "pop from an empty queue")

endmodule
`default_nettype wire

// ===== hw/rtl/clps_back.sv =====
`default_nettype none
`include "char_lcd_parallel_sequencer_core_defines.svh"
module clps_back #(
  parameter int unsigned WAIT_BITS = clps_pkg::WAIT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [clps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [clps_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          q_valid_i,
  input  wire clps_pkg::entry_t              q_entry_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output clps_pkg::out_item_t                out_item_o
);

  localparam int unsigned CFG_W = clps_pkg::CFG_W;

  // Fit a 16-bit register value into the wait counter.
  function automatic logic [WAIT_BITS-1:0] to_wait(input logic [CFG_W-1:0] v);
    logic [CFG_W+WAIT_BITS-1:0] ext;
    ext = {{WAIT_BITS{1'b0}}, v};
    return ext[WAIT_BITS-1:0];
  endfunction

  logic [CFG_W-1:0] power_up_q, settle_q, long_q;

  clps_pkg::phase_e   phase_q, phase_d;
  clps_pkg::init_e    init_q, init_d;
  logic [3:0]         step_q, step_d;
  logic [WAIT_BITS-1:0] wait_q, wait_d;
  logic [7:0]         byte_q, byte_d;
  logic               sel_q, sel_d;
  logic               long_flag_q, long_flag_d;
  logic               rej_d;

  logic                out_valid_q, out_valid_d;
  clps_pkg::out_item_t out_q, res_d;

  // Take the next queued item whenever the output register is free or drains.
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = q_pop_o || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_up_q <= clps_pkg::POWER_UP_WAIT_RST;
      settle_q <= clps_pkg::SETTLE_WAIT_RST;
      long_q <= clps_pkg::LONG_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (clps_pkg::cfg_idx_e'(cfg_idx_i))
        clps_pkg::CFG_POWER_UP: power_up_q <= cfg_data_i;
        clps_pkg::CFG_SETTLE:   settle_q <= cfg_data_i;
        clps_pkg::CFG_LONG:     long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer for the item being taken.
  always_comb begin
    logic       enter;
    logic [3:0] enter_step;
    enter = 1'b0;
    enter_step = step_q;
    phase_d = phase_q;
    init_d = init_q;
    step_d = step_q;
    wait_d = wait_q;
    byte_d = byte_q;
    sel_d = sel_q;
    long_flag_d = long_flag_q;
    rej_d = 1'b0;

    if (q_pop_o) begin
      if (q_entry_i.kind == clps_pkg::KIND_TICK) begin
        if (phase_q == clps_pkg::PH_PULSE) begin
          phase_d = clps_pkg::PH_SETTLE;
          wait_d = to_wait(settle_q);
        end else if (phase_q != clps_pkg::PH_IDLE) begin
          if (wait_q > WAIT_BITS'(1)) begin
            wait_d = wait_q - 1'b1;
          end else begin
            wait_d = '0;
            if (phase_q == clps_pkg::PH_SETTLE && long_flag_q) begin
              phase_d = clps_pkg::PH_LONG;
              wait_d = to_wait(long_q);
            end else if (init_q == clps_pkg::INIT_RUN) begin
              step_d = step_q + 1'b1;
              enter = 1'b1;
              enter_step = step_q + 1'b1;
            end else begin
              phase_d = clps_pkg::PH_IDLE;
            end
          end
        end
      end else if (phase_q != clps_pkg::PH_IDLE ||
                   q_entry_i.kind == clps_pkg::KIND_BAD) begin
        rej_d = 1'b1;
      end else if (q_entry_i.kind == clps_pkg::KIND_INIT) begin
        if (init_q != clps_pkg::INIT_NONE) begin
          rej_d = 1'b1;
        end else begin
          init_d = clps_pkg::INIT_RUN;
          step_d = clps_pkg::STEP_POWER_UP;
          enter = 1'b1;
          enter_step = clps_pkg::STEP_POWER_UP;
        end
      end else begin
        byte_d = q_entry_i.wr_byte;
        sel_d = q_entry_i.wr_select;
        long_flag_d = q_entry_i.wr_long;
        phase_d = clps_pkg::PH_PULSE;
      end
    end

    // Start one position of the power-up sequence.
    if (enter) begin
      unique case (enter_step) inside
        clps_pkg::STEP_POWER_UP: begin
          phase_d = clps_pkg::PH_GAP;
          wait_d = to_wait(power_up_q);
        end
        clps_pkg::STEP_WAKE_1, clps_pkg::STEP_WAKE_2, clps_pkg::STEP_WAKE_3: begin
          phase_d = clps_pkg::PH_PULSE;
          byte_d = clps_pkg::BYTE_WAKE;
          sel_d = 1'b0;
          long_flag_d = 1'b0;
        end
        clps_pkg::STEP_GAP_A: begin
          phase_d = clps_pkg::PH_GAP;
          wait_d = WAIT_BITS'(clps_pkg::GAP_A_US);
        end
        clps_pkg::STEP_GAP_B: begin
          phase_d = clps_pkg::PH_GAP;
          wait_d = WAIT_BITS'(clps_pkg::GAP_B_US);
        end
        clps_pkg::STEP_FUNC: begin
          phase_d = clps_pkg::PH_PULSE;
          byte_d = clps_pkg::BYTE_FUNC_INIT;
          sel_d = 1'b0;
          long_flag_d = 1'b0;
        end
        clps_pkg::STEP_DISP_OFF: begin
          phase_d = clps_pkg::PH_PULSE;
          byte_d = clps_pkg::BYTE_DISP_OFF;
          sel_d = 1'b0;
          long_flag_d = 1'b0;
        end
        clps_pkg::STEP_CLEAR: begin
          phase_d = clps_pkg::PH_PULSE;
          byte_d = clps_pkg::BYTE_CLEAR;
          sel_d = 1'b0;
          long_flag_d = 1'b1;
        end
        clps_pkg::STEP_ENTRY: begin
          phase_d = clps_pkg::PH_PULSE;
          byte_d = clps_pkg::BYTE_ENTRY_INIT;
          sel_d = 1'b0;
          long_flag_d = 1'b0;
        end
        default: begin
          init_d = clps_pkg::INIT_DONE;
          phase_d = clps_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Pin levels and status that follow from the new state.
  always_comb begin
    logic pulse;
    pulse = (phase_d == clps_pkg::PH_PULSE);
    res_d.reg_select = pulse && sel_d;
    res_d.read_write = 1'b0;
    res_d.enable = pulse;
    res_d.bus_data = pulse ? byte_d : 8'h00;
    res_d.busy_res = (phase_d != clps_pkg::PH_IDLE);
    res_d.rejected = rej_d;
    res_d.ready_res = (init_d == clps_pkg::INIT_DONE);
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clps_pkg::PH_IDLE;
      init_q <= clps_pkg::INIT_NONE;
      step_q <= '0;
      wait_q <= '0;
      byte_q <= '0;
      sel_q <= 1'b0;
      long_flag_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      init_q <= init_d;
      step_q <= step_d;
      wait_q <= wait_d;
      byte_q <= byte_d;
      sel_q <= sel_d;
      long_flag_q <= long_flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res_d;
    end
  end

  `CLPS_ASSERT_IMP(a_back_pulse_busy, out_valid_q && out_q.enable, out_q.busy_res,
                   "enable pulse shown while not busy")
  `CLPS_ASSERT_NXT(a_back_ready_sticks, init_q == clps_pkg::INIT_DONE,
                   init_q == clps_pkg::INIT_DONE, "power-up completion was lost")
  `CLPS_ASSERT_IMP(a_back_wait_phase, wait_q != '0,
                   phase_q == clps_pkg::PH_SETTLE || phase_q == clps_pkg::PH_LONG ||
                   phase_q == clps_pkg::PH_GAP,
                   "wait count left over outside a waiting phase")

endmodule
`default_nettype wire

// ===== hw/rtl/char_lcd_parallel_sequencer_core.sv =====
// Character LCD sequencer for an HD44780-style display on an 8-bit bus.
// Input channel (in_valid_i / in_stall_o / in_item_i): each item is either a
// one-microsecond tick (mode 0) or a command request (mode 1). Output channel
// (out_valid_o / out_stall_i / out_item_o): exactly one result item per input
// item, in order, giving the RS, RW, E and D7..D0 pin levels after that item,
// plus busy, rejected and ready status.
// Configuration (cfg_we_i / cfg_idx_i / cfg_data_i): index 0 power-up wait,
// 1 settle wait, 2 long wait, all in microseconds; write only while idle.
// A result passes through the classify queue and then the output register; an
// item enters the queue when accepted, and a receiver stall can hold it there.
// Throughput: one item per cycle while the receiver does not stall; every item is
// a single state update of the sequencer, so the two-entry queue never limits the rate.
// When the receiver stalls, the result holds in the output register and the
// queue fills; in_stall_o rises once both queue entries are taken.
// Reset returns the sequencer to idle, not initialized, with the register
// defaults of 30000, 90 and 4000 microseconds, and empties the queue.
`default_nettype none
module char_lcd_parallel_sequencer_core #(
  parameter int unsigned WAIT_BITS = clps_pkg::WAIT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [clps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [clps_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire clps_pkg::in_item_t             in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output clps_pkg::out_item_t                 out_item_o
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  clps_pkg::entry_t front_entry;
  clps_pkg::entry_t q_entry;

  // Classify incoming items.
  clps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  // Short queue between classification and execution.
  clps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // Sequencer and output register.
  clps_back #(
    .WAIT_BITS (WAIT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import clps_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [3:0] FIRST_BAD_CODE = 4'(CMD_DATA + 1);
  localparam logic [3:0] LAST_BAD_CODE = 4'hF;

  // Predicts the pin levels and status after every accepted item and checks
  // the results of the block against them in order.
  class lcd_pin_scoreboard;
    logic [15:0] power_up_us;
    logic [15:0] settle_us;
    logic [15:0] long_us;
    phase_e      phase;
    logic [3:0]  init_step;
    logic [15:0] wait_left;
    logic [7:0]  pend_byte;
    logic        pend_select;
    logic        pend_long;
    init_e       init_st;
    out_item_t   expected_pins[$];
    int          failures;

    function new();
      power_up_us = POWER_UP_WAIT_RST;
      settle_us = SETTLE_WAIT_RST;
      long_us = LONG_WAIT_RST;
      phase = PH_IDLE;
      init_step = STEP_POWER_UP;
      wait_left = '0;
      pend_byte = '0;
      pend_select = 1'b0;
      pend_long = 1'b0;
      init_st = INIT_NONE;
      failures = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_POWER_UP: power_up_us = data;
        CFG_SETTLE: settle_us = data;
        CFG_LONG: long_us = data;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function bit ready();
      return init_st == INIT_DONE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function void load_write(logic [7:0] data, logic sel, logic lng);
      pend_byte = data;
      pend_select = sel;
      pend_long = lng;
      phase = PH_PULSE;
    endfunction

    function void load_wait(phase_e ph, logic [15:0] n);
      phase = ph;
      wait_left = n;
    endfunction

    // Enter the current step of the power-up sequence.
    function void enter_step();
      case (init_step)
        STEP_POWER_UP: load_wait(PH_GAP, power_up_us);
        STEP_WAKE_1, STEP_WAKE_2, STEP_WAKE_3: load_write(BYTE_WAKE, 1'b0, 1'b0);
        STEP_GAP_A: load_wait(PH_GAP, 16'(GAP_A_US));
        STEP_GAP_B: load_wait(PH_GAP, 16'(GAP_B_US));
        STEP_FUNC: load_write(BYTE_FUNC_INIT, 1'b0, 1'b0);
        STEP_DISP_OFF: load_write(BYTE_DISP_OFF, 1'b0, 1'b0);
        STEP_CLEAR: load_write(BYTE_CLEAR, 1'b0, 1'b1);
        STEP_ENTRY: load_write(BYTE_ENTRY_INIT, 1'b0, 1'b0);
        default: begin
          init_st = INIT_DONE;
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void finish_wait();
      if (init_st == INIT_RUN) begin
        init_step = init_step + 4'd1;
        enter_step();
      end else begin
        phase = PH_IDLE;
      end
    endfunction

    // One microsecond passes: end the pulse or count down the wait.
    function void tick_us();
      if (phase == PH_IDLE) return;
      if (phase == PH_PULSE) begin
        load_wait(PH_SETTLE, settle_us);
        return;
      end
      if (wait_left > 16'd1) begin
        wait_left = wait_left - 16'd1;
        return;
      end
      wait_left = '0;
      if (phase == PH_SETTLE && pend_long) load_wait(PH_LONG, long_us);
      else finish_wait();
    endfunction

    // Returns 1 when the command starts a write or the power-up sequence.
    function bit start_command(in_item_t it);
      if (phase != PH_IDLE) return 1'b0;
      case (it.command)
        CMD_INIT: begin
          if (init_st != INIT_NONE) return 1'b0;
          init_st = INIT_RUN;
          init_step = STEP_POWER_UP;
          enter_step();
        end
        CMD_CLEAR: load_write(BYTE_CLEAR, 1'b0, 1'b1);
        CMD_HOME: load_write(BYTE_HOME, 1'b0, 1'b1);
        CMD_ENTRY: load_write(BASE_ENTRY | {6'b0, it.flag_a, 1'b0}, 1'b0, 1'b0);
        CMD_DISPLAY:
          load_write(BASE_DISPLAY | {5'b0, it.flag_a, it.flag_b, it.flag_c}, 1'b0, 1'b0);
        CMD_SHIFT: load_write(BASE_SHIFT | {4'b0, it.flag_a, it.flag_b, 2'b0}, 1'b0, 1'b0);
        CMD_FUNCTION:
          load_write(BASE_FUNC | {3'b0, it.flag_a, it.flag_b, it.flag_c, 2'b0}, 1'b0, 1'b0);
        CMD_CGRAM: load_write(BASE_CGRAM | {2'b0, it.value[5:0]}, 1'b0, 1'b0);
        CMD_DDRAM: load_write(BASE_DDRAM | {1'b0, it.value[6:0]}, 1'b0, 1'b0);
        CMD_DATA: load_write(it.value, 1'b1, 1'b0);
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Apply one accepted item and queue the pin levels that follow it.
    function void note_item(in_item_t it);
      out_item_t pins;
      logic      refused;
      refused = 1'b0;
      if (!it.mode) tick_us();
      else refused = !start_command(it);
      pins.reg_select = (phase == PH_PULSE) ? pend_select : 1'b0;
      pins.read_write = 1'b0;
      pins.enable = (phase == PH_PULSE);
      pins.bus_data = (phase == PH_PULSE) ? pend_byte : 8'h00;
      pins.busy_res = (phase != PH_IDLE);
      pins.rejected = refused;
      pins.ready_res = (init_st == INIT_DONE);
      expected_pins.push_back(pins);
    endfunction

    function void compare_pin(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        failures++;
      end
    endfunction

    function void check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        $error("result %h arrived with no item outstanding", got);
        failures++;
        return;
      end
      want = expected_pins.pop_front();
      compare_pin("reg_select", 8'(want.reg_select), 8'(got.reg_select));
      compare_pin("read_write", 8'(want.read_write), 8'(got.read_write));
      compare_pin("enable", 8'(want.enable), 8'(got.enable));
      compare_pin("bus_data", want.bus_data, got.bus_data);
      compare_pin("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_pin("rejected", 8'(want.rejected), 8'(got.rejected));
      compare_pin("ready_res", 8'(want.ready_res), 8'(got.ready_res));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  lcd_pin_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;
  int quiet_cycles;

  char_lcd_parallel_sequencer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (out_valid && !out_stall) sb.check_pins(out_item);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t tick_item();
    logic [15:0] raw;
    in_item_t    it;
    raw = 16'($urandom);
    it = raw;
    it.mode = 1'b0;
    return it;
  endfunction

  task automatic tick_until_idle();
    while (sb.busy()) send_item(tick_item());
  endtask

  task automatic send_cmd(logic [3:0] code, logic a, logic b, logic c, logic [7:0] v,
                          bit settle);
    in_item_t it;
    it = '{mode: 1'b1, command: code, flag_a: a, flag_b: b, flag_c: c, value: v};
    send_item(it);
    if (settle) tick_until_idle();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all three registers once the block has delivered every result.
  task automatic configure(logic [15:0] power_up, logic [15:0] settle,
                           logic [15:0] long_wait);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_POWER_UP;
    cfg_data <= power_up;
    sb.set_reg(CFG_POWER_UP, power_up);
    @(negedge clk);
    cfg_idx <= CFG_SETTLE;
    cfg_data <= settle;
    sb.set_reg(CFG_SETTLE, settle);
    @(negedge clk);
    cfg_idx <= CFG_LONG;
    cfg_data <= long_wait;
    sb.set_reg(CFG_LONG, long_wait);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly commands while idle and ticks while busy; the rest is noise.
  function automatic in_item_t random_item(bit allow_init);
    logic [15:0] raw;
    in_item_t    it;
    int          pick;
    raw = 16'($urandom);
    it = raw;
    pick = $urandom_range(99);
    it.mode = sb.busy() ? (pick < 12) : (pick < 80);
    if (it.mode) begin
      pick = $urandom_range(99);
      if (pick < 88) it.command = 4'($urandom_range(CMD_DATA, CMD_CLEAR));
      else if (pick < 94) it.command = 4'($urandom_range(LAST_BAD_CODE, FIRST_BAD_CODE));
      else it.command = allow_init ? CMD_INIT : CMD_DATA;
    end
    return it;
  endfunction

  // Ticks that arrive while idle do not count toward n.
  task automatic run_random(int n, bit allow_init);
    int       counted;
    in_item_t it;
    counted = 0;
    while (counted < n) begin
      it = random_item(allow_init);
      if (it.mode || sb.busy()) counted++;
      send_item(it);
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_POWER_UP;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    send_idle_pct = 11;
    recv_idle_pct = 54;
    hold_request = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: every command before init, busy and unknown codes.
    configure(16'hFFFF, 16'd1, 16'd2);
    send_item(in_item_t'(16'h7FFF));
    send_cmd(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(CMD_DATA, 1'b1, 1'b1, 1'b1, 8'hA5, 1'b0);
    tick_until_idle();
    send_cmd(CMD_HOME, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(CMD_ENTRY, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1);
    send_cmd(CMD_ENTRY, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(CMD_DISPLAY, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
    send_cmd(CMD_SHIFT, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
    send_cmd(CMD_FUNCTION, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
    send_cmd(CMD_FUNCTION, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b1);
    send_cmd(CMD_CGRAM, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b1);
    send_cmd(CMD_DDRAM, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(CMD_DATA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    send_cmd(CMD_DATA, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(FIRST_BAD_CODE, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
    send_cmd(LAST_BAD_CODE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    configure(16'hFFFF, 16'd0, 16'd0);
    send_cmd(CMD_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    send_cmd(CMD_DATA, 1'b0, 1'b0, 1'b0, 8'h41, 1'b1);

    // Random commands before the power-up sequence.
    run_random(200, 1'b0);
    configure(16'hFFFF, 16'd1, 16'd3);
    run_random(200, 1'b0);
    configure(16'hFFFF, 16'($urandom_range(6)), 16'($urandom_range(6)));
    run_random(200, 1'b0);

    // Power-up sequence with noise; init is refused once it has started.
    send_idle_pct = 54;
    recv_idle_pct = 11;
    configure(16'd0, 16'd2, 16'd3);
    send_cmd(CMD_INIT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(CMD_INIT, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
    while (!sb.ready()) send_item(random_item(1'b1));
    send_cmd(CMD_INIT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    configure(16'd0, 16'd1, 16'd1);
    run_random(300, 1'b1);
    configure(16'd0, 16'($urandom_range(6)), 16'($urandom_range(6)));
    run_random(300, 1'b1);

    // No idling; one long receiver hold-off fills the block.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'd0, 16'd0, 16'd2);
    run_random(150, 1'b1);
    hold_request = 1'b1;
    run_random(250, 1'b1);

    // Longest extra wait; the run ends while it is still counting down.
    configure(16'd0, 16'd0, 16'hFFFF);
    send_cmd(CMD_HOME, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    send_item(tick_item());
    send_item(tick_item());
    send_cmd(CMD_DATA, 1'b1, 1'b0, 1'b1, 8'hC3, 1'b0);
    repeat (4) send_item(tick_item());

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
